// File: hdl/mtrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_pkg
// Types, codes and helpers shared by the MTRR memory type lookup.
// ----------------------------------------------------------------------------
package mtrr_pkg;

    localparam int FIXED_WORDS = 11;

    localparam logic [7:0] TYPE_UC = 8'd0;
    localparam logic [7:0] TYPE_WT = 8'd4;
    localparam logic [7:0] TYPE_WB = 8'd6;

    // first fixed word that covers 4 KiB steps (0xC0000 and up)
    localparam logic [3:0] FIX_4K_FIRST = 4'd3;
    localparam logic [3:0] FIX_16K_LOW  = 4'd1;
    localparam logic [3:0] FIX_16K_HIGH = 4'd2;
    localparam logic [3:0] FIX_64K      = 4'd0;

    typedef enum logic [1:0] {
        ACT_FIXED  = 2'd0,
        ACT_BASE   = 2'd1,
        ACT_MASK   = 2'd2,
        ACT_LOOKUP = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        SRC_OFF     = 2'd0,
        SRC_FIXED   = 2'd1,
        SRC_VAR     = 2'd2,
        SRC_DEFAULT = 2'd3
    } t_source;

    typedef enum logic [1:0] {
        REG_MTRR_EN  = 2'd0,
        REG_FIXED_EN = 2'd1,
        REG_DEFAULT  = 2'd2,
        REG_PAIR_CNT = 2'd3
    } t_reg;

    // one word travelling down the chain
    typedef struct packed {
        t_action     action;
        logic [3:0]  slot;
        logic [63:0] wval;
        logic [51:0] addr;
        logic [7:0]  mtype;
        t_source     src;
        logic        hit;
        logic        conflict;
    } t_token;

    typedef struct packed {
        logic       mtrr_en;
        logic       fixed_en;
        logic [7:0] default_type;
        logic [4:0] pair_cnt;
    } t_cfg;

    typedef struct packed {
        logic [3:0] idx;
        logic [2:0] sel;
    } t_fixed_pos;

    // word and byte of the fixed range that covers an address below 1 MiB
    function automatic t_fixed_pos fixed_locate(input logic [19:0] a);
        t_fixed_pos p;
        if (!a[19]) begin
            p.idx = FIX_64K;
            p.sel = a[18:16];
        end else if (!a[18]) begin
            p.idx = a[17] ? FIX_16K_HIGH : FIX_16K_LOW;
            p.sel = a[16:14];
        end else begin
            p.idx = FIX_4K_FIRST + {1'b0, a[17:15]};
            p.sel = a[14:12];
        end
        return p;
    endfunction

endpackage

// File: hdl/mtrr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface mtrr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [3:0]  slot;
    logic [63:0] write_value;
    logic [51:0] lookup_address;

    modport source (output valid, action, slot, write_value, lookup_address,
                    input ready);
    modport sink   (input valid, action, slot, write_value, lookup_address,
                    output ready);
endinterface

interface mtrr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] memory_type;
    logic       conflict;
    logic [1:0] type_src;

    modport source (output valid, memory_type, conflict, type_src, input ready);
    modport sink   (input valid, memory_type, conflict, type_src, output ready);
endinterface

// File: hdl/mtrr_head.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_head
// Fixed-range store and first stage: resolves disabled and fixed lookups.
// ----------------------------------------------------------------------------
module mtrr_head
    import mtrr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    input  t_token i_tok,
    output logic   o_valid,
    output t_token o_tok
);

    logic [63:0] r_fixed [0:FIXED_WORDS-1];
    logic        r_valid;
    t_token      r_tok;
    t_token      n_tok;
    t_fixed_pos  w_pos;
    logic [63:0] w_word;

    assign w_pos  = fixed_locate(i_tok.addr[19:0]);
    assign w_word = r_fixed[w_pos.idx];

    always_comb begin
        n_tok          = i_tok;
        n_tok.mtype    = TYPE_UC;
        n_tok.hit      = 1'b0;
        n_tok.conflict = 1'b0;
        priority if (!i_cfg.mtrr_en) begin
            n_tok.src = SRC_OFF;
        end else if (i_tok.addr[51:20] == '0 && i_cfg.fixed_en) begin
            n_tok.src   = SRC_FIXED;
            n_tok.mtype = w_word[{w_pos.sel, 3'b000} +: 8];
        end else begin
            // leave for the variable chain
            n_tok.src = SRC_VAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid && i_tok.action == ACT_FIXED
                && i_tok.slot < 4'(FIXED_WORDS)) begin
            r_fixed[i_tok.slot] <= i_tok.wval;
        end
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

// File: hdl/mtrr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_cell
// One variable base/mask pair; merges its type into passing lookups.
// ----------------------------------------------------------------------------
module mtrr_cell
    import mtrr_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [4:0] i_pair_cnt,
    input  logic       i_valid,
    input  t_token     i_tok,
    output logic       o_valid,
    output t_token     o_tok
);

    logic [51:0] r_base_hi;
    logic [7:0]  r_base_ty;
    logic [51:0] r_mask_hi;
    logic        r_mask_vld;
    logic        r_valid;
    t_token      r_tok;
    t_token      n_tok;
    logic        w_mine;
    logic        w_active;
    logic        w_match;
    logic [51:0] w_addr_hi;

    assign w_mine    = {1'b0, i_tok.slot} == 5'(CELL_IDX);
    assign w_active  = 5'(CELL_IDX) < i_pair_cnt;
    assign w_addr_hi = {12'b0, i_tok.addr[51:12]};
    assign w_match   = (w_addr_hi & r_mask_hi) == (r_base_hi & r_mask_hi);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.action == ACT_LOOKUP && i_tok.src == SRC_VAR && w_active
                && !i_tok.conflict && r_mask_vld && w_match) begin
            priority if (!i_tok.hit || i_tok.mtype == r_base_ty) begin
                n_tok.mtype = r_base_ty;
            end else if (i_tok.mtype == TYPE_UC || r_base_ty == TYPE_UC) begin
                n_tok.mtype = TYPE_UC;
            end else if ((i_tok.mtype == TYPE_WB && r_base_ty == TYPE_WT)
                    || (i_tok.mtype == TYPE_WT && r_base_ty == TYPE_WB)) begin
                n_tok.mtype = TYPE_WT;
            end else begin
                // unmergeable pair: report UC and ignore the rest
                n_tok.mtype    = TYPE_UC;
                n_tok.conflict = 1'b1;
            end
            n_tok.hit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid && w_mine) begin
            if (i_tok.action == ACT_BASE) begin
                r_base_hi <= i_tok.wval[63:12];
                r_base_ty <= i_tok.wval[7:0];
            end
            if (i_tok.action == ACT_MASK) begin
                r_mask_hi  <= i_tok.wval[63:12];
                r_mask_vld <= i_tok.wval[11];
            end
        end
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

// File: hdl/mtrr_memory_type_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_memory_type_lookup
// x86 MTRR memory type resolution over fixed and variable ranges.
// ----------------------------------------------------------------------------
// Every request word (fixed write, base write, mask write or lookup) enters a
// head stage, then passes one cell per variable pair, then an output register;
// a new word is taken every cycle while the result side keeps up. Writes flow
// down the same chain, so a lookup always sees every earlier write and none
// after it. Writes give no result. The whole chain holds while a result waits
// unaccepted at the output.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8 and 12.
module mtrr_memory_type_lookup
    import mtrr_pkg::*;
#(
    parameter int VARIABLE_PAIRS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtrr_in_if.sink     i_lookup,
    mtrr_out_if.source  o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_mtrr_en;
    logic       r_fixed_en;
    logic [7:0] r_default;
    logic [4:0] r_pair_cnt;
    t_cfg       w_cfg;
    t_reg       w_reg;

    logic       w_adv;
    t_token     w_in_tok;
    logic       w_vld [0:VARIABLE_PAIRS];
    t_token     w_tok [0:VARIABLE_PAIRS];
    t_token     w_tail;

    logic       r_out_valid;
    logic [7:0] r_out_type;
    logic       r_out_conf;
    t_source    r_out_src;

    // configuration port
    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtrr_en  <= 1'b0;
            r_fixed_en <= 1'b0;
            r_default  <= 8'd0;
            r_pair_cnt <= 5'd0;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_MTRR_EN:  r_mtrr_en  <= pwdata[0];
                REG_FIXED_EN: r_fixed_en <= pwdata[0];
                REG_DEFAULT:  r_default  <= pwdata[7:0];
                REG_PAIR_CNT: r_pair_cnt <= pwdata[4:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_MTRR_EN:  prdata = {31'b0, r_mtrr_en};
            REG_FIXED_EN: prdata = {31'b0, r_fixed_en};
            REG_DEFAULT:  prdata = {24'b0, r_default};
            REG_PAIR_CNT: prdata = {27'b0, r_pair_cnt};
        endcase
    end

    assign w_cfg = '{mtrr_en: r_mtrr_en, fixed_en: r_fixed_en,
                     default_type: r_default, pair_cnt: r_pair_cnt};

    // advance the chain unless a result is stuck at the output
    assign w_adv          = !r_out_valid || o_result.ready;
    assign i_lookup.ready = w_adv;

    always_comb begin
        w_in_tok          = '0;
        w_in_tok.action   = t_action'(i_lookup.action);
        w_in_tok.slot     = i_lookup.slot;
        w_in_tok.wval     = i_lookup.write_value;
        w_in_tok.addr     = i_lookup.lookup_address;
    end

    mtrr_head u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cfg   (w_cfg),
        .i_valid (i_lookup.valid),
        .i_tok   (w_in_tok),
        .o_valid (w_vld[0]),
        .o_tok   (w_tok[0])
    );

    for (genvar g = 0; g < VARIABLE_PAIRS; g++) begin : g_cell
        mtrr_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_pair_cnt (r_pair_cnt),
            .i_valid    (w_vld[g]),
            .i_tok      (w_tok[g]),
            .o_valid    (w_vld[g+1]),
            .o_tok      (w_tok[g+1])
        );
    end

    assign w_tail = w_tok[VARIABLE_PAIRS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_vld[VARIABLE_PAIRS] && w_tail.action == ACT_LOOKUP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_conf <= w_tail.conflict;
            if (w_tail.src == SRC_VAR && !w_tail.hit) begin
                r_out_type <= r_default;
                r_out_src  <= SRC_DEFAULT;
            end else begin
                r_out_type <= w_tail.mtype;
                r_out_src  <= w_tail.src;
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.memory_type = r_out_type;
    assign o_result.conflict    = r_out_conf;
    assign o_result.type_src    = r_out_src;

`ifndef SYNTHESIS
    a_conflict_is_var_uc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_conf |-> r_out_src == SRC_VAR && r_out_type == TYPE_UC)
        else $error("conflict result not reported as variable UC");

    a_off_is_uc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_src == SRC_OFF |-> r_out_type == TYPE_UC && !r_out_conf)
        else $error("disabled lookup returned a cached type");

    a_tail_lookup_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_vld[VARIABLE_PAIRS] && w_tail.action == ACT_LOOKUP |=> r_out_valid)
        else $error("lookup word lost at the end of the chain");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && !(w_vld[VARIABLE_PAIRS] && w_tail.action == ACT_LOOKUP) |=> !r_out_valid)
        else $error("result raised without a lookup word");
`endif

endmodule

// File: tb/mtrr_memory_type_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_memory_type_lookup_tb
// Self-checking bench for the MTRR memory type lookup. Request words (fixed
// word, variable base and mask writes, lookups) go in on the request
// channel. A behavioral copy of the fixed and variable MTRR state resolves
// every accepted lookup. Each result word is then checked field by field
// against the oldest outstanding prediction. Directed cases come first, then
// randomized traffic under several idle/stall mixes and register settings.
// ----------------------------------------------------------------------------
module mtrr_memory_type_lookup_tb;
    import mtrr_pkg::*;

    localparam int VAR_PAIRS      = 16;
    localparam int LATENCY        = VAR_PAIRS + 2;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [63:0] PAIR_VALID = 64'h800;

    typedef struct packed {
        logic [7:0] mtype;
        logic       conflict;
        t_source    src;
    } t_mem_attr;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mtrr_in_if  lookup_ch ();
    mtrr_out_if result_ch ();

    mtrr_memory_type_lookup #(
        .VARIABLE_PAIRS(VAR_PAIRS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lookup (lookup_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the block's state
    logic [63:0] fixed_word [FIXED_WORDS];
    logic [63:0] var_base   [VAR_PAIRS];
    logic [63:0] var_mask   [VAR_PAIRS];
    logic        mtrr_on;
    logic        fixed_on;
    logic [7:0]  dflt_type;
    logic [4:0]  pair_count;

    t_mem_attr   pending_types [$];
    int          errors        = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_left     = 0;
    int unsigned quiet_cycles  = 0;

    function automatic t_mem_attr resolve_type(logic [51:0] addr);
        t_mem_attr   r;
        logic [63:0] a64;
        logic [63:0] b;
        logic [63:0] m;
        logic [7:0]  acc;
        logic [7:0]  cur;
        logic        hit;
        int          ai;
        int          idx;
        int          start;
        int          step;
        int          lane;
        int          n;
        r.mtype    = TYPE_UC;
        r.conflict = 1'b0;
        r.src      = SRC_OFF;
        if (!mtrr_on)
            return r;
        if (addr < 52'h100000 && fixed_on) begin
            ai = int'(addr[19:0]);
            if (ai < 'h80000) begin
                idx   = 0;
                start = 0;
                step  = 'h10000;
            end else if (ai < 'hC0000) begin
                idx   = 1 + (ai - 'h80000) / 'h20000;
                start = 'h80000 + (idx - 1) * 'h20000;
                step  = 'h4000;
            end else begin
                idx   = 3 + (ai - 'hC0000) / 'h8000;
                start = 'hC0000 + (idx - 3) * 'h8000;
                step  = 'h1000;
            end
            lane    = ((ai - start) / step) & 7;
            r.mtype = fixed_word[idx][lane*8 +: 8];
            r.src   = SRC_FIXED;
            return r;
        end
        a64 = {12'd0, addr};
        n   = (pair_count > VAR_PAIRS) ? VAR_PAIRS : int'(pair_count);
        hit = 1'b0;
        acc = TYPE_UC;
        for (int i = 0; i < n && !r.conflict; i++) begin
            b   = var_base[i];
            m   = var_mask[i];
            cur = b[7:0];
            if (!m[11])
                continue;
            b[11:0] = '0;
            m[11:0] = '0;
            if ((a64 & m) != (b & m))
                continue;
            if (!hit || acc == cur) begin
                acc = cur;
            end else if (acc == TYPE_UC || cur == TYPE_UC) begin
                acc = TYPE_UC;
            end else if ((acc == TYPE_WB && cur == TYPE_WT) ||
                         (acc == TYPE_WT && cur == TYPE_WB)) begin
                acc = TYPE_WT;
            end else begin
                // unmergeable pair: report UC and stop merging
                r.conflict = 1'b1;
                acc        = TYPE_UC;
            end
            hit = 1'b1;
        end
        if (hit) begin
            r.mtype = acc;
            r.src   = SRC_VAR;
        end else begin
            r.mtype = dflt_type;
            r.src   = SRC_DEFAULT;
        end
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [51:0] rand_addr();
        logic [63:0] t;
        t = rand64();
        return t[51:0];
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom_range(7))
            0, 1:    return TYPE_UC;
            2, 3:    return TYPE_WT;
            4, 5:    return TYPE_WB;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [63:0] make_base();
        logic [63:0] b;
        b = rand64();
        if ($urandom_range(9) != 0)
            b[63:52] = '0;
        b[7:0] = pick_type();
        return b;
    endfunction

    function automatic logic [63:0] make_mask();
        logic [63:0] m;
        if ($urandom_range(7) == 0)
            m = rand64();
        else
            m = ~64'd0 << $urandom_range(51, 12);
        m[10:0] = 11'($urandom_range(2047));
        m[11]   = ($urandom_range(9) != 0);
        return m;
    endfunction

    function automatic logic [51:0] pick_address();
        logic [63:0] t;
        int unsigned j;
        t = rand64();
        case ($urandom_range(9))
            0, 1, 2: return {32'd0, t[19:0]};
            3, 4, 5, 6: begin
                // land inside the range of a random pair
                j = $urandom_range(VAR_PAIRS - 1);
                return (var_base[j][51:0] & var_mask[j][51:0]) |
                       (t[51:0] & ~var_mask[j][51:0]);
            end
            7:       return t[51:0];
            8:       return {20'd0, t[31:0]};
            default: return 52'h0FF000 + {39'd0, t[12:0]};
        endcase
    endfunction

    task automatic send_word(t_action act, logic [3:0] slot, logic [63:0] wval,
                             logic [51:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            lookup_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        lookup_ch.valid          <= 1'b1;
        lookup_ch.action         <= act;
        lookup_ch.slot           <= slot;
        lookup_ch.write_value    <= wval;
        lookup_ch.lookup_address <= addr;
        do
            @(posedge i_clk);
        while (!lookup_ch.ready);
        case (act)
            ACT_FIXED:  if (slot < FIXED_WORDS) fixed_word[slot] = wval;
            ACT_BASE:   var_base[slot] = wval;
            ACT_MASK:   var_mask[slot] = wval;
            ACT_LOOKUP: pending_types.push_back(resolve_type(addr));
        endcase
    endtask

    task automatic lookup(logic [51:0] addr);
        send_word(ACT_LOOKUP, 4'($urandom_range(15)), rand64(), addr);
    endtask

    task automatic store(t_action act, logic [3:0] slot, logic [63:0] wval);
        send_word(act, slot, wval, rand_addr());
    endtask

    task automatic random_word();
        int unsigned r;
        logic [3:0]  s;
        r = $urandom_range(99);
        s = 4'($urandom_range(15));
        if (r < 5)
            store(ACT_FIXED, s, rand64());
        else if (r < 12)
            store(ACT_BASE, s, make_base());
        else if (r < 20)
            store(ACT_MASK, s, make_mask());
        else
            lookup(pick_address());
    endtask

    // drop valid, wait out results and any writes still in the chain
    task automatic drain();
        @(negedge i_clk);
        lookup_ch.valid <= 1'b0;
        while (pending_types.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg r, logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (r)
            REG_MTRR_EN:  mtrr_on    = v[0];
            REG_FIXED_EN: fixed_on   = v[0];
            REG_DEFAULT:  dflt_type  = v[7:0];
            REG_PAIR_CNT: pair_count = v[4:0];
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(logic en, logic fix, logic [7:0] dflt, logic [4:0] cnt);
        cfg_write(REG_MTRR_EN,  {31'd0, en});
        cfg_write(REG_FIXED_EN, {31'd0, fix});
        cfg_write(REG_DEFAULT,  {24'd0, dflt});
        cfg_write(REG_PAIR_CNT, {27'd0, cnt});
    endtask

    // fill every store entry so no lookup ever reads an unwritten one
    task automatic load_tables();
        for (int i = 0; i < FIXED_WORDS; i++)
            store(ACT_FIXED, 4'(i), rand64());
        for (int i = 0; i < VAR_PAIRS; i++) begin
            store(ACT_BASE, 4'(i), make_base());
            store(ACT_MASK, 4'(i), make_mask());
        end
    endtask

    task automatic test_disabled();
        lookup(52'h0);
        lookup(52'hF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_fixed_ranges();
        drain();
        set_config(1'b1, 1'b1, 8'hFF, 5'd0);
        store(ACT_FIXED, 4'd0, 64'h0706_0504_0302_0100);
        store(ACT_FIXED, 4'd10, 64'hFFFF_FFFF_FFFF_FFFF);
        store(ACT_FIXED, 4'd15, 64'h0);
        lookup(52'h00000);
        lookup(52'h7FFFF);
        lookup(52'h80000);
        lookup(52'hBFFFF);
        lookup(52'hC0000);
        lookup(52'hFFFFF);
        lookup(52'h100000);
    endtask

    task automatic test_variable_merge();
        drain();
        set_config(1'b1, 1'b0, 8'hA5, 5'd3);
        store(ACT_BASE, 4'd0, {56'd0, TYPE_WB});
        store(ACT_MASK, 4'd0, (~64'd0 << 32) | PAIR_VALID);
        store(ACT_BASE, 4'd1, 64'h8000_0000 | {56'd0, TYPE_WT});
        store(ACT_MASK, 4'd1, (~64'd0 << 30) | PAIR_VALID);
        store(ACT_BASE, 4'd2, 64'hC000_0000 | {56'd0, TYPE_UC});
        store(ACT_MASK, 4'd2, (~64'd0 << 30) | PAIR_VALID);
        lookup(52'h1000_0000);
        lookup(52'h8000_1000);
        lookup(52'hC000_0000);
        lookup(52'h1000);
        // write-combining against write-back cannot be merged
        store(ACT_BASE, 4'd2, 64'hC000_0001);
        lookup(52'hC000_0000);
        lookup(52'h1_0000_0000);
        store(ACT_MASK, 4'd1, ~64'd0 << 30);
        lookup(52'h8000_1000);
        drain();
        cfg_write(REG_PAIR_CNT, 32'd31);
        lookup(52'h1000_0000);
    endtask

    task automatic test_backpressure();
        drain();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 300;
        repeat (80) random_word();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 80; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 80; end
                default: begin send_idle_pct = 18; stall_pct = 18; end
            endcase
            for (int s = 0; s < 4; s++) begin
                drain();
                case (s)
                    0: set_config(1'b1, 1'b1, 8'h00, 5'd16);
                    1: set_config(1'b1, 1'b0, 8'hFF, 5'd31);
                    2: set_config($urandom_range(3) != 0, $urandom_range(1) != 0,
                                  8'($urandom_range(255)), 5'($urandom_range(31)));
                    default: set_config(1'b1, 1'b1, 8'($urandom_range(255)),
                                        5'($urandom_range(17, 1)));
                endcase
                repeat (97) random_word();
            end
        end
    endtask

    task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
        errors++;
        $error("%s: expected %0d, got %0d", name, want, got);
    endtask

    always @(posedge i_clk) begin : check_results
        t_mem_attr want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_types.size() == 0) begin
                errors++;
                $error("result word with no lookup outstanding");
            end else begin
                want = pending_types.pop_front();
                if (result_ch.memory_type !== want.mtype)
                    report_field("memory_type", want.mtype, result_ch.memory_type);
                if (result_ch.conflict !== want.conflict)
                    report_field("conflict", {7'd0, want.conflict},
                                 {7'd0, result_ch.conflict});
                if (result_ch.type_src !== want.src)
                    report_field("source", {6'd0, want.src}, {6'd0, result_ch.type_src});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((lookup_ch.valid && lookup_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        i_rst_n                  = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        lookup_ch.valid          = 1'b0;
        lookup_ch.action         = ACT_FIXED;
        lookup_ch.slot           = '0;
        lookup_ch.write_value    = '0;
        lookup_ch.lookup_address = '0;
        mtrr_on                  = 1'b0;
        fixed_on                 = 1'b0;
        dflt_type                = '0;
        pair_count               = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_tables();
        test_disabled();
        test_fixed_ranges();
        test_variable_merge();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (LATENCY) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hdl/mtrr_pkg.sv
hdl/mtrr_if.sv
hdl/mtrr_head.sv
hdl/mtrr_cell.sv
hdl/mtrr_memory_type_lookup.sv
tb/mtrr_memory_type_lookup_tb.sv
